// ===== design/tcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal code converter package
// Shared constants, codes and types for the code / temperature converter.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int CODE_BITS_DEF = 10;
  localparam int TEMP_W        = 21;
  localparam int OFFSET_W      = 20;
  localparam int SLOPE_W       = 10;
  localparam int RAW_W         = 12;
  localparam int TIN_W         = 32;
  localparam int DIFF_W        = 21;
  localparam int VALID_BIT     = 11;
  localparam int APB_AW        = 3;
  localparam int APB_DW        = 32;

  localparam logic [OFFSET_W-1:0]     OFFSET_RESET   = OFFSET_W'(410040);
  localparam logic [SLOPE_W-1:0]      SLOPE_RESET    = SLOPE_W'(487);
  localparam logic signed [TIN_W-1:0] TEMP_MIN_LIMIT = -TIN_W'(88161);

  // Register index, taken from paddr bit 2.
  localparam logic REG_OFFSET = 1'b0;
  localparam logic REG_SLOPE  = 1'b1;

  typedef enum logic [1:0] {
    MODE_STATUS    = 2'd0,
    MODE_CODE      = 2'd1,
    MODE_ROUND_UP  = 2'd2,
    MODE_ROUND_DN  = 2'd3
  } tcc_mode_e;

  // Per-request control that travels down the pipeline.
  typedef struct packed {
    logic                     is_code;
    logic                     round_up;
    logic                     clamp_neg;
    logic                     sat_max;
    logic                     zero;
    logic                     invalid;
    logic signed [TEMP_W-1:0] temp;
  } tcc_meta_t;

endpackage

// ===== design/tcc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal code converter front end
// Two register stages: decode, multiply and difference, then temperature
// clamp and divider range check.
// ----------------------------------------------------------------------------
module tcc_front #(
  parameter int CODE_BITS = tcc_pkg::CODE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic [1:0]                            mode_i,
  input  logic [tcc_pkg::RAW_W-1:0]             raw_word_i,
  input  logic signed [tcc_pkg::TIN_W-1:0]      temp_in_i,
  input  logic [tcc_pkg::OFFSET_W-1:0]          offset_i,
  input  logic [tcc_pkg::SLOPE_W-1:0]           slope_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output tcc_pkg::tcc_meta_t                    meta_o,
  output logic [((CODE_BITS+10 > 21) ? CODE_BITS+10 : 21)-1:0] rem_o
);
  import tcc_pkg::*;

  localparam int PW = CODE_BITS + SLOPE_W;
  localparam int DW = (PW > DIFF_W) ? PW : DIFF_W;
  localparam int TW = ((PW > OFFSET_W) ? PW : OFFSET_W) + 1;
  localparam logic signed [TW-1:0] T_MAX = TW'(1048575);
  localparam logic signed [TW-1:0] T_MIN = ~T_MAX;

  // Stage A: decode, multiply, difference.
  logic                valid_a_q;
  tcc_meta_t           meta_a_d, meta_a_q;
  logic [DIFF_W-1:0]   diff_a_d, diff_a_q;
  logic [PW-1:0]       prod_a_d, prod_a_q;
  logic [CODE_BITS-1:0] code_sel;
  logic                below, above;
  logic [TIN_W:0]      diff_full;
  logic                ready_b;

  // Stage B.
  logic                valid_b_q;
  tcc_meta_t           meta_b_d, meta_b_q;
  logic [DW-1:0]       rem_b_d, rem_b_q;
  logic signed [TW-1:0] t_full;
  logic signed [TEMP_W-1:0] t_sat;
  logic                ovf;

  always_comb begin
    meta_a_d = '0;
    code_sel = '0;
    unique case (tcc_mode_e'(mode_i))
      MODE_STATUS: begin
        meta_a_d.invalid   = ~raw_word_i[VALID_BIT];
        meta_a_d.clamp_neg = 1'b1;
        code_sel           = CODE_BITS'(raw_word_i[10:1]);
      end
      MODE_CODE: begin
        code_sel = CODE_BITS'(raw_word_i);
      end
      MODE_ROUND_UP: begin
        meta_a_d.is_code  = 1'b1;
        meta_a_d.round_up = 1'b1;
      end
      MODE_ROUND_DN: begin
        meta_a_d.is_code = 1'b1;
      end
      default: ;
    endcase
    below = temp_in_i < TEMP_MIN_LIMIT;
    above = $signed({temp_in_i[TIN_W-1], temp_in_i}) >=
            $signed({{(TIN_W+1-OFFSET_W){1'b0}}, offset_i});
    diff_full = {{(TIN_W+1-OFFSET_W){1'b0}}, offset_i} - {temp_in_i[TIN_W-1], temp_in_i};
    diff_a_d  = diff_full[DIFF_W-1:0];
    meta_a_d.zero    = above;
    meta_a_d.sat_max = below | ((slope_i == '0) & ~above);
    prod_a_d  = PW'(code_sel) * PW'(slope_i);
  end

  assign ready_b = ~valid_b_q | ready_i;
  assign ready_o = ~valid_a_q | ready_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else begin
      if (ready_o) valid_a_q <= valid_i;
      if (ready_b) valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      meta_a_q <= meta_a_d;
      diff_a_q <= diff_a_d;
      prod_a_q <= prod_a_d;
    end
    if (valid_a_q && ready_b) begin
      meta_b_q <= meta_b_d;
      rem_b_q  <= rem_b_d;
    end
  end

  // Stage B: temperature line with saturation, and quotient range check.
  always_comb begin
    t_full = TW'(offset_i) - TW'(prod_a_q);
    if (t_full > T_MAX) begin
      t_sat = T_MAX[TEMP_W-1:0];
    end else if (t_full < T_MIN) begin
      t_sat = T_MIN[TEMP_W-1:0];
    end else begin
      t_sat = t_full[TEMP_W-1:0];
    end
    if (meta_a_q.clamp_neg && t_sat < 0) t_sat = '0;
    // A quotient of 2^CODE_BITS or more saturates at the maximum code.
    ovf      = DW'(diff_a_q) >= (DW'(slope_i) << CODE_BITS);
    meta_b_d = meta_a_q;
    meta_b_d.temp = (meta_a_q.invalid || meta_a_q.is_code) ? '0 : t_sat;
    meta_b_d.sat_max = meta_a_q.sat_max | (ovf & ~meta_a_q.zero);
    rem_b_d  = DW'(diff_a_q);
  end

  assign valid_o = valid_b_q;
  assign meta_o  = meta_b_q;
  assign rem_o   = rem_b_q;

endmodule

// ===== design/tcc_div_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal code converter divider step
// One registered restoring-division step that resolves one quotient bit.
// ----------------------------------------------------------------------------
module tcc_div_step #(
  parameter int CODE_BITS = tcc_pkg::CODE_BITS_DEF,
  parameter int SHIFT     = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  tcc_pkg::tcc_meta_t            meta_i,
  input  logic [((CODE_BITS+10 > 21) ? CODE_BITS+10 : 21)-1:0] rem_i,
  input  logic [CODE_BITS-1:0]          quo_i,
  input  logic [tcc_pkg::SLOPE_W-1:0]   slope_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output tcc_pkg::tcc_meta_t            meta_o,
  output logic [((CODE_BITS+10 > 21) ? CODE_BITS+10 : 21)-1:0] rem_o,
  output logic [CODE_BITS-1:0]          quo_o
);
  import tcc_pkg::*;

  localparam int DW = (CODE_BITS + SLOPE_W > DIFF_W) ? CODE_BITS + SLOPE_W : DIFF_W;

  logic                 valid_q;
  tcc_meta_t            meta_q;
  logic [DW-1:0]        rem_d, rem_q, divisor;
  logic [CODE_BITS-1:0] quo_d, quo_q;

  always_comb begin
    divisor = DW'(slope_i) << SHIFT;
    rem_d   = rem_i;
    quo_d   = quo_i;
    if (rem_i >= divisor) begin
      rem_d        = rem_i - divisor;
      quo_d[SHIFT] = 1'b1;
    end
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      meta_q <= meta_i;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
    end
  end

  assign valid_o = valid_q;
  assign meta_o  = meta_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;

endmodule

// ===== design/tcc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal code converter back end
// Rounding, code saturation and the output register.
// ----------------------------------------------------------------------------
module tcc_back #(
  parameter int CODE_BITS = tcc_pkg::CODE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  tcc_pkg::tcc_meta_t                   meta_i,
  input  logic [((CODE_BITS+10 > 21) ? CODE_BITS+10 : 21)-1:0] rem_i,
  input  logic [CODE_BITS-1:0]                 quo_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic signed [tcc_pkg::TEMP_W-1:0]    temp_o,
  output logic [CODE_BITS-1:0]                 code_o,
  output logic                                 invalid_o
);
  import tcc_pkg::*;

  logic                     valid_q;
  logic signed [TEMP_W-1:0] temp_q;
  logic [CODE_BITS-1:0]     code_d, code_q;
  logic                     invalid_q;
  logic [CODE_BITS:0]       quo_inc;

  always_comb begin
    quo_inc = {1'b0, quo_i} + (CODE_BITS+1)'(meta_i.round_up && (rem_i != '0));
    code_d  = '0;
    if (meta_i.is_code) begin
      if (meta_i.sat_max || quo_inc[CODE_BITS]) begin
        code_d = '1;
      end else if (!meta_i.zero) begin
        code_d = quo_inc[CODE_BITS-1:0];
      end
    end
    // The zero case wins over the maximum: a temperature at or above the
    // offset is handled ahead of the zero-slope case.
    if (meta_i.is_code && meta_i.zero) code_d = '0;
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      temp_q    <= meta_i.temp;
      code_q    <= code_d;
      invalid_q <= meta_i.invalid;
    end
  end

  assign valid_o   = valid_q;
  assign temp_o    = temp_q;
  assign code_o    = code_q;
  assign invalid_o = invalid_q;

endmodule

// ===== design/thermal_code_temp_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal code / temperature converter
// Converts sensor codes to millidegrees and millidegrees to sensor codes.
// ----------------------------------------------------------------------------
// Usage: a request carries mode_i, raw_word_i and temp_in_i on the input
// channel (in_valid_i / in_ready_o). Each request yields exactly one result
// on the output channel (out_valid_o / out_ready_i) with temp_out_o,
// code_out_o and invalid_o, in request order.
// From acceptance to a valid result, a request passes two front stages
// (decode and multiply, then clamp and range check), one restoring divider
// stage per quotient bit, and the output register. Throughput is one request
// per cycle while the receiver takes results. Every stage has its own valid
// bit and takes a new request whenever it is empty or its successor takes its
// content, so bubbles are squeezed out while the receiver stalls, and a
// stalled result holds in the output register until it is taken.
// Reset clears all valid bits and loads the offset and slope registers with
// their defaults; there is no clearing pass. The user must write the offset
// and slope over the APB port only while the block is idle; the block does
// not enforce this, and the pipeline reads the live register values.
// ----------------------------------------------------------------------------
module thermal_code_temp_converter #(
  parameter int CODE_BITS = tcc_pkg::CODE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Request channel.
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         mode_i,
  input  logic [tcc_pkg::RAW_W-1:0]          raw_word_i,
  input  logic signed [tcc_pkg::TIN_W-1:0]   temp_in_i,
  // Result channel.
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [tcc_pkg::TEMP_W-1:0]  temp_out_o,
  output logic [CODE_BITS-1:0]               code_out_o,
  output logic                               invalid_o,
  // APB configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tcc_pkg::APB_AW-1:0]         paddr,
  input  logic [tcc_pkg::APB_DW-1:0]         pwdata,
  output logic [tcc_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);
  import tcc_pkg::*;

  localparam int DW = (CODE_BITS + SLOPE_W > DIFF_W) ? CODE_BITS + SLOPE_W : DIFF_W;

  // Configuration registers.
  logic [OFFSET_W-1:0] offset_q;
  logic [SLOPE_W-1:0]  slope_q;
  logic                apb_write;

  assign pready    = 1'b1;
  assign apb_write = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OFFSET_RESET;
      slope_q  <= SLOPE_RESET;
    end else if (apb_write) begin
      unique case (paddr[2])
        REG_OFFSET: offset_q <= pwdata[OFFSET_W-1:0];
        REG_SLOPE:  slope_q  <= pwdata[SLOPE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_OFFSET: prdata = APB_DW'(offset_q);
      REG_SLOPE:  prdata = APB_DW'(slope_q);
      default: ;
    endcase
  end

  // Pipeline links: index k feeds divider step k; the last feeds the back end.
  logic [CODE_BITS:0]   stg_valid;
  logic [CODE_BITS:0]   stg_ready;
  tcc_meta_t            stg_meta [CODE_BITS+1];
  logic [DW-1:0]        stg_rem  [CODE_BITS+1];
  logic [CODE_BITS-1:0] stg_quo  [CODE_BITS+1];

  assign stg_quo[0] = '0;

  tcc_front #(.CODE_BITS(CODE_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_i),
    .ready_o    (in_ready_o),
    .mode_i     (mode_i),
    .raw_word_i (raw_word_i),
    .temp_in_i  (temp_in_i),
    .offset_i   (offset_q),
    .slope_i    (slope_q),
    .valid_o    (stg_valid[0]),
    .ready_i    (stg_ready[0]),
    .meta_o     (stg_meta[0]),
    .rem_o      (stg_rem[0])
  );

  // Quotient bits are resolved from the most significant one down.
  for (genvar k = 0; k < CODE_BITS; k++) begin : g_div
    tcc_div_step #(.CODE_BITS(CODE_BITS), .SHIFT(CODE_BITS - 1 - k)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[k]),
      .ready_o (stg_ready[k]),
      .meta_i  (stg_meta[k]),
      .rem_i   (stg_rem[k]),
      .quo_i   (stg_quo[k]),
      .slope_i (slope_q),
      .valid_o (stg_valid[k+1]),
      .ready_i (stg_ready[k+1]),
      .meta_o  (stg_meta[k+1]),
      .rem_o   (stg_rem[k+1]),
      .quo_o   (stg_quo[k+1])
    );
  end

  tcc_back #(.CODE_BITS(CODE_BITS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (stg_valid[CODE_BITS]),
    .ready_o   (stg_ready[CODE_BITS]),
    .meta_i    (stg_meta[CODE_BITS]),
    .rem_i     (stg_rem[CODE_BITS]),
    .quo_i     (stg_quo[CODE_BITS]),
    .valid_o   (out_valid_o),
    .ready_i   (out_ready_i),
    .temp_o    (temp_out_o),
    .code_o    (code_out_o),
    .invalid_o (invalid_o)
  );

endmodule

// ===== design/tcc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal code converter checker
// Port-level assertions, bound to the converter top level.
// ----------------------------------------------------------------------------
module tcc_checker #(
  parameter int CODE_BITS = tcc_pkg::CODE_BITS_DEF
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic [1:0]                         mode_i,
  input logic [tcc_pkg::RAW_W-1:0]          raw_word_i,
  input logic signed [tcc_pkg::TIN_W-1:0]   temp_in_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [tcc_pkg::TEMP_W-1:0]  temp_out_o,
  input logic [CODE_BITS-1:0]               code_out_o,
  input logic                               invalid_o,
  input logic                               psel,
  input logic                               penable,
  input logic                               pwrite,
  input logic [tcc_pkg::APB_AW-1:0]         paddr,
  input logic [tcc_pkg::APB_DW-1:0]         pwdata,
  input logic [tcc_pkg::APB_DW-1:0]         prdata,
  input logic                               pready
);
  import tcc_pkg::*;

  // A waiting request keeps its valid and its payload until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(mode_i) &&
      $stable(raw_word_i) && $stable(temp_in_i))
    else $error("request changed while waiting");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(temp_out_o) &&
      $stable(code_out_o) && $stable(invalid_o))
    else $error("result changed while stalled");

  // An invalid status word carries no temperature and no code.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_o |-> temp_out_o == '0 && code_out_o == '0)
    else $error("invalid result carries data");

  // A code result never comes with a temperature or an invalid flag.
  a_code_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && code_out_o != '0 |-> temp_out_o == '0 && !invalid_o)
    else $error("code result mixed with temperature result");

  // A written offset reads back on the next cycle.
  a_offset_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr[2] == REG_OFFSET |=>
      paddr[2] != REG_OFFSET || prdata[OFFSET_W-1:0] == $past(pwdata[OFFSET_W-1:0]))
    else $error("offset register readback mismatch");

endmodule

bind thermal_code_temp_converter tcc_checker #(.CODE_BITS(CODE_BITS)) u_tcc_checker (.*);
